FILE: sv/palette_color_map_assert.svh
// Assertion macros used by the checker.
`ifndef PALETTE_COLOR_MAP_ASSERT_SVH
`define PALETTE_COLOR_MAP_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define PCM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during rst.
`define PCM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pcm_pkg.sv
package pcm_pkg;

  localparam int MAX_ENTRIES_DEF = 256;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int POS_W      = 32;
  localparam int CHAN_W     = 8;
  localparam int COLOR_W    = 3 * CHAN_W;
  localparam int INDEX_W    = 8;
  localparam int COUNT_W    = 9;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd1;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_CONT_CLAMP = 2'd0,
    MODE_CONT_WRAP  = 2'd1,
    MODE_DISC_CLAMP = 2'd2,
    MODE_DISC_WRAP  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_ADDR,
    ST_READ,
    ST_BLEND
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: sv/palette_color_map.sv
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_ready    op, entry_index, entry_red/green/blue, position
// out      out  out_valid/out_ready  red, green, blue
// cfg      in   cfg_wen (no wait)    cfg_index, cfg_data
//
// Write item: stored in the accept cycle; no result.
// Lookup item: from accept it steps through prepare, address, palette read, blend
//   and back to idle before the next accept; discrete wrap adds a divide step
//   after prepare for the bit-serial remainder unit.
// rst clears control, mode and count; the palette is undefined until written.
// A held result stalls the next lookup at its blend step, with the input closed.
module palette_color_map #(
  parameter int MAX_ENTRIES = pcm_pkg::MAX_ENTRIES_DEF,
  parameter int FRAC_BITS   = pcm_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_wen,
  input  logic [pcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcm_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input items
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               op,
  input  logic [pcm_pkg::INDEX_W-1:0]        entry_index,
  input  logic [pcm_pkg::CHAN_W-1:0]         entry_red,
  input  logic [pcm_pkg::CHAN_W-1:0]         entry_green,
  input  logic [pcm_pkg::CHAN_W-1:0]         entry_blue,
  input  logic signed [pcm_pkg::POS_W-1:0]   position,
  // result items
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pcm_pkg::CHAN_W-1:0]         red,
  output logic [pcm_pkg::CHAN_W-1:0]         green,
  output logic [pcm_pkg::CHAN_W-1:0]         blue
);

  localparam int AW   = $clog2(MAX_ENTRIES);
  localparam int NW   = pcm_pkg::COUNT_W;
  localparam int PW   = pcm_pkg::POS_W;
  localparam int XW   = FRAC_BITS + 1;          // position in [0, ONE]
  localparam int XXW  = XW + NW;                // x * (n - 1)
  localparam int QW   = PW - FRAC_BITS;         // integer magnitude
  localparam int CW   = (QW > NW) ? QW : NW;
  localparam int ONE  = 1 << FRAC_BITS;
  localparam int LOW  = (ONE + 5000) / 10000;
  localparam int HIGH = ONE - LOW;

  // Configuration registers
  pcm_pkg::mode_t mode;
  logic [NW-1:0]  entry_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= pcm_pkg::MODE_CONT_CLAMP;
      entry_count <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        pcm_pkg::REG_MODE:        mode <= pcm_pkg::mode_t'(cfg_data[pcm_pkg::MODE_W-1:0]);
        pcm_pkg::REG_ENTRY_COUNT: entry_count <= cfg_data[NW-1:0];
        default: ;
      endcase
    end
  end

  // Counts above the store depth act as the depth.
  logic [NW-1:0] n_act;
  logic [NW-1:0] n_m1;

  assign n_act = (32'(entry_count) > 32'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES) : entry_count;
  assign n_m1  = n_act - NW'(1);

  // Control
  pcm_pkg::state_t state;
  pcm_pkg::state_t state_next;
  logic            accept;
  logic            div_start;
  logic            load_out;
  pcm_pkg::div_stat_t div_stat;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      pcm_pkg::ST_IDLE: begin
        if (accept && op == pcm_pkg::OP_LOOKUP) state_next = pcm_pkg::ST_PREP;
      end
      pcm_pkg::ST_PREP: begin
        state_next = (mode == pcm_pkg::MODE_DISC_WRAP) ? pcm_pkg::ST_DIV : pcm_pkg::ST_ADDR;
      end
      pcm_pkg::ST_DIV: begin
        if (div_stat.done) state_next = pcm_pkg::ST_ADDR;
      end
      pcm_pkg::ST_ADDR:  state_next = pcm_pkg::ST_READ;
      pcm_pkg::ST_READ:  state_next = pcm_pkg::ST_BLEND;
      pcm_pkg::ST_BLEND: begin
        if (!out_valid || out_ready) state_next = pcm_pkg::ST_IDLE;
      end
      default: state_next = pcm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == pcm_pkg::ST_IDLE);
    div_start = (state == pcm_pkg::ST_PREP) && (mode == pcm_pkg::MODE_DISC_WRAP);
    load_out  = (state == pcm_pkg::ST_BLEND) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the lookup position for the whole walk.
  logic signed [PW-1:0] pos;

  always_ff @(posedge clk) begin
    if (accept && op == pcm_pkg::OP_LOOKUP) begin
      pos <= position;
    end
  end

  // Palette write: drop indexes at or beyond the active count.
  logic                   wr_en;
  logic [AW+pcm_pkg::INDEX_W-1:0] wr_idx_ext;
  logic [pcm_pkg::COLOR_W-1:0]    wr_data;

  assign wr_en      = accept && (op == pcm_pkg::OP_WRITE) && (NW'(entry_index) < n_act);
  assign wr_idx_ext = (AW + pcm_pkg::INDEX_W)'(entry_index);
  assign wr_data    = {entry_red, entry_green, entry_blue};

  // Continuous modes: pick x in [0, ONE] and scale by n - 1.
  logic [XW-1:0]  x_sel;
  logic [XXW-1:0] xx;

  always_comb begin
    case (mode)
      pcm_pkg::MODE_CONT_CLAMP: begin
        if (pos[PW-1])        x_sel = XW'(LOW);
        else if (pos > ONE)   x_sel = XW'(HIGH);
        else                  x_sel = pos[XW-1:0];
      end
      pcm_pkg::MODE_CONT_WRAP: x_sel = {1'b0, pos[FRAC_BITS-1:0]};
      default:                 x_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == pcm_pkg::ST_PREP) begin
      xx <= XXW'(x_sel) * XXW'(n_m1);
    end
  end

  // Discrete modes: integer part truncated toward zero.
  logic          neg;
  logic [PW-1:0] mag;
  logic [QW-1:0] q;

  assign neg = pos[PW-1];
  assign mag = neg ? PW'(-pos) : PW'(pos);
  assign q   = mag[PW-1:FRAC_BITS];

  logic [NW-1:0] rem;

  pcm_mod_unit #(
    .DIVIDEND_W (QW),
    .DIVISOR_W  (NW)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (q),
    .divisor   (n_act),
    .stat      (div_stat),
    .remainder (rem)
  );

  // Address generation
  logic [NW:0]     base_raw;
  logic [NW:0]     n_m2;
  logic [NW:0]     base;
  logic [XXW-1:0]  alpha_full;
  logic [NW-1:0]   idx_a;
  logic [NW-1:0]   idx_b;
  logic [XW-1:0]   alpha_next;
  logic [AW+NW-1:0] idx_a_ext;
  logic [AW+NW-1:0] idx_b_ext;

  assign base_raw   = xx[XXW-1:FRAC_BITS];
  assign n_m2       = (NW + 1)'(n_act) - (NW + 1)'(2);
  assign base       = (base_raw > n_m2) ? n_m2 : base_raw;
  assign alpha_full = xx - XXW'({base, {FRAC_BITS{1'b0}}});

  always_comb begin
    idx_a      = '0;
    idx_b      = '0;
    alpha_next = '0;
    case (mode)
      pcm_pkg::MODE_CONT_CLAMP, pcm_pkg::MODE_CONT_WRAP: begin
        // A single entry blends entry 0 with itself.
        if (n_act != NW'(1)) begin
          idx_a      = base[NW-1:0];
          idx_b      = base[NW-1:0] + NW'(1);
          alpha_next = alpha_full[XW-1:0];
        end
      end
      pcm_pkg::MODE_DISC_CLAMP: begin
        if (neg)                        idx_a = '0;
        else if (CW'(q) >= CW'(n_act))  idx_a = n_m1;
        else                            idx_a = NW'(q);
        idx_b = idx_a;
      end
      pcm_pkg::MODE_DISC_WRAP: begin
        idx_a = (neg && rem != '0) ? (n_act - rem) : rem;
        idx_b = idx_a;
      end
      default: ;
    endcase
  end

  assign idx_a_ext = (AW + NW)'(idx_a);
  assign idx_b_ext = (AW + NW)'(idx_b);

  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  logic [XW-1:0] alpha;
  logic          black;

  always_ff @(posedge clk) begin
    if (state == pcm_pkg::ST_ADDR) begin
      rd_addr_a <= idx_a_ext[AW-1:0];
      rd_addr_b <= idx_b_ext[AW-1:0];
      alpha     <= alpha_next;
      black     <= (n_act == '0);
    end
  end

  // Palette: two identical copies give the two neighbouring reads per cycle.
  // Writes only land in ST_IDLE and reads matter only later, so no forwarding.
  logic [pcm_pkg::COLOR_W-1:0] c0;
  logic [pcm_pkg::COLOR_W-1:0] c1;

  pcm_ram #(
    .WIDTH (pcm_pkg::COLOR_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx_ext[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr_a),
    .rd_data (c0)
  );

  pcm_ram #(
    .WIDTH (pcm_pkg::COLOR_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx_ext[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr_b),
    .rd_data (c1)
  );

  // Blend and output register. The read addresses stay put while the
  // blend step waits on a held output, so the read data stays valid too.
  logic [pcm_pkg::COLOR_W-1:0] blended;
  logic [pcm_pkg::COLOR_W-1:0] color;

  pcm_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .c0    (c0),
    .c1    (c1),
    .alpha (alpha),
    .color (blended)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      color <= black ? '0 : blended;
    end
  end

  assign red   = color[2*pcm_pkg::CHAN_W +: pcm_pkg::CHAN_W];
  assign green = color[pcm_pkg::CHAN_W +: pcm_pkg::CHAN_W];
  assign blue  = color[0 +: pcm_pkg::CHAN_W];

endmodule

FILE: sv/pcm_ram.sv
module pcm_ram #(
  parameter int WIDTH = pcm_pkg::COLOR_W,
  parameter int DEPTH = pcm_pkg::MAX_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/pcm_mod_unit.sv
// Restoring remainder, one dividend bit per cycle.
module pcm_mod_unit #(
  parameter int DIVIDEND_W = pcm_pkg::POS_W - pcm_pkg::FRAC_BITS_DEF,
  parameter int DIVISOR_W  = pcm_pkg::COUNT_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output pcm_pkg::div_stat_t    stat,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] shift;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    trial_sub;
  logic [DIVISOR_W-1:0]  rem_next;

  // Remainder stays below the divisor, so trial stays below twice it.
  assign trial     = {rem, shift[DIVIDEND_W-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign rem_next  = (trial >= {1'b0, divisor}) ? trial_sub[DIVISOR_W-1:0]
                                                : trial[DIVISOR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shift <= shift << 1;
      rem   <= rem_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign remainder = rem;

endmodule

FILE: sv/pcm_blend.sv
// Per channel: c0 + (c1 - c0) * alpha, rounded half up.
module pcm_blend #(
  parameter int FRAC_BITS = pcm_pkg::FRAC_BITS_DEF
) (
  input  logic [pcm_pkg::COLOR_W-1:0] c0,
  input  logic [pcm_pkg::COLOR_W-1:0] c1,
  input  logic [FRAC_BITS:0]          alpha,
  output logic [pcm_pkg::COLOR_W-1:0] color
);

  localparam int CW = pcm_pkg::CHAN_W;
  localparam int PW = FRAC_BITS + CW + 3;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  logic signed [FRAC_BITS+1:0] alpha_s;

  assign alpha_s = $signed({1'b0, alpha});

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    logic [CW-1:0]        a;
    logic [CW-1:0]        b;
    logic signed [CW:0]   diff;
    logic signed [PW-1:0] base_term;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] acc;

    assign a         = c0[ch*CW +: CW];
    assign b         = c1[ch*CW +: CW];
    assign diff      = $signed({1'b0, b}) - $signed({1'b0, a});
    assign base_term = $signed(PW'({a, {FRAC_BITS{1'b0}}}));
    assign prod      = PW'(diff) * PW'(alpha_s);
    assign acc       = base_term + prod + HALF;
    assign color[ch*CW +: CW] = acc[FRAC_BITS +: CW];
  end

endmodule

FILE: sv/pcm_checker.sv
`include "palette_color_map_assert.svh"

module pcm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       op,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [pcm_pkg::CHAN_W-1:0] red,
  input logic [pcm_pkg::CHAN_W-1:0] green,
  input logic [pcm_pkg::CHAN_W-1:0] blue
);

  // A held result keeps its colour.
  `PCM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(red) && $stable(green) && $stable(blue), "held result changed")

  // A lookup closes the input until it is done.
  `PCM_ASSERT_NXT(a_lookup_busy, in_valid && in_ready && op == pcm_pkg::OP_LOOKUP, !in_ready, "input open during lookup")

  // A write leaves the input open.
  `PCM_ASSERT_NXT(a_write_open, in_valid && in_ready && op == pcm_pkg::OP_WRITE, in_ready, "input closed after write")

  // No result can appear the cycle after any accept.
  `PCM_ASSERT_NXT(a_no_early, in_valid && in_ready, !$rose(out_valid), "result too early")

endmodule

bind palette_color_map pcm_checker u_pcm_checker (.*);
